/* rtl/core/spmf_pkg.sv */
// Package: shared widths, register indexes, sequencer states and reset values.
`default_nettype none

package spmf_pkg;

  // Fixed field widths
  localparam int unsigned COEF_W   = 40;
  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned DIST_W   = 8;
  localparam int unsigned REG_IDX_W = 3;

  // Horner accumulator: each multiply by the 8-bit sample (zero-extended) grows it by 9 bits
  localparam int unsigned ACC_W = COEF_W + 3 * (SAMPLE_W + 1);

  // Configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_COEF_CUBIC  = 3'd0,
    REG_COEF_SQUARE = 3'd1,
    REG_COEF_LINEAR = 3'd2,
    REG_COEF_OFFSET = 3'd3,
    REG_HIGH_THR    = 3'd4,
    REG_HIGH_VAL    = 3'd5,
    REG_LOW_THR     = 3'd6,
    REG_LOW_VAL     = 3'd7
  } reg_idx_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_STORE,
    ST_MEDIAN,
    ST_EMIT
  } state_e;

  // Register reset values
  localparam logic signed [COEF_W-1:0] COEF_CUBIC_RST  = -40'sd3663;
  localparam logic signed [COEF_W-1:0] COEF_SQUARE_RST = 40'sd1090519;
  localparam logic signed [COEF_W-1:0] COEF_LINEAR_RST = -40'sd121248940;
  localparam logic signed [COEF_W-1:0] COEF_OFFSET_RST = 40'sd5874709955;
  localparam logic [DIST_W-1:0]        HIGH_THR_RST    = 8'd180;
  localparam logic [DIST_W-1:0]        HIGH_VAL_RST    = 8'd245;
  localparam logic [DIST_W-1:0]        LOW_THR_RST     = 8'd40;
  localparam logic [DIST_W-1:0]        LOW_VAL_RST     = 8'd0;

endpackage

`default_nettype wire

/* rtl/core/sensor_poly_median_filter.sv */
// Infrared distance linearizer (cubic, shared multiply-accumulate) with median-of-group filter.
// Per sample the sequencer accepts and loads it, runs 3 multiply-accumulate steps on the
//   shared MAC and 1 saturate-and-store step; in_ready_o stays low until it is idle again.
// Every GROUP_SIZE-th sample adds a median scan over the group and an emit step, so its result
//   is registered in ST_EMIT, which waits while an older result is not taken.
// Reset (asynchronous, active low) loads the register defaults and empties the group.
`default_nettype none

module sensor_poly_median_filter
  import spmf_pkg::*;
#(
  parameter int unsigned GROUP_SIZE    = 5,
  parameter int unsigned FRACTION_BITS = 24
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  input  wire logic                cfg_we_i,
  input  wire logic [REG_IDX_W-1:0] cfg_index_i,
  input  wire logic [COEF_W-1:0]   cfg_data_i,

  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire logic [SAMPLE_W-1:0] raw_sample_i,

  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      logic [DIST_W-1:0]   filtered_distance_o
);

  localparam int unsigned IDX_W = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
  localparam int unsigned CNT_W = $clog2(GROUP_SIZE + 1);
  localparam logic [CNT_W-1:0] MID_POS  = CNT_W'(GROUP_SIZE / 2);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GROUP_SIZE - 1);
  localparam logic [1:0]       LAST_STEP = 2'd3;

  // Configuration registers
  logic signed [COEF_W-1:0] coef_q [4];
  logic [DIST_W-1:0] high_thr_q, high_val_q, low_thr_q, low_val_q;

  // Sequencer and datapath registers
  state_e                 state_q, state_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [SAMPLE_W-1:0]    x_q, x_d;
  logic [1:0]             step_q, step_d;
  logic [IDX_W-1:0]       fill_q, fill_d;
  logic [IDX_W-1:0]       cand_q, cand_d;
  logic [DIST_W-1:0]      med_q, med_d;
  logic                   out_valid_q, out_valid_d;
  logic [DIST_W-1:0]      out_data_q, out_data_d;

  // Group store, written once per sample, no reset
  logic [DIST_W-1:0] group_q [GROUP_SIZE];
  logic              store_we;

  // Shared MAC and helpers
  logic signed [ACC_W+SAMPLE_W:0] mac_prod;
  logic signed [ACC_W-1:0]        mac_sum;
  logic signed [COEF_W-1:0]       coef_sel;
  logic [DIST_W-1:0]              conv_dist;
  logic [DIST_W-1:0]              cand_val;
  logic [CNT_W-1:0]               lt_cnt, le_cnt;
  logic                           cand_match;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0]  <= COEF_CUBIC_RST;
      coef_q[1]  <= COEF_SQUARE_RST;
      coef_q[2]  <= COEF_LINEAR_RST;
      coef_q[3]  <= COEF_OFFSET_RST;
      high_thr_q <= HIGH_THR_RST;
      high_val_q <= HIGH_VAL_RST;
      low_thr_q  <= LOW_THR_RST;
      low_val_q  <= LOW_VAL_RST;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_COEF_CUBIC:  coef_q[0]  <= cfg_data_i;
        REG_COEF_SQUARE: coef_q[1]  <= cfg_data_i;
        REG_COEF_LINEAR: coef_q[2]  <= cfg_data_i;
        REG_COEF_OFFSET: coef_q[3]  <= cfg_data_i;
        REG_HIGH_THR:    high_thr_q <= cfg_data_i[DIST_W-1:0];
        REG_HIGH_VAL:    high_val_q <= cfg_data_i[DIST_W-1:0];
        REG_LOW_THR:     low_thr_q  <= cfg_data_i[DIST_W-1:0];
        REG_LOW_VAL:     low_val_q  <= cfg_data_i[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Multiply-accumulate: acc * x + next coefficient
  assign coef_sel = coef_q[step_q];
  assign mac_prod = acc_q * $signed({1'b0, x_q});
  assign mac_sum  = mac_prod[ACC_W-1:0]
                  + {{(ACC_W - COEF_W){coef_sel[COEF_W-1]}}, coef_sel};

  // Floor, drop negatives to zero, saturate above the 8-bit range
  always_comb begin
    if (acc_q[ACC_W-1]) begin
      conv_dist = '0;
    end else if (|acc_q[ACC_W-2:FRACTION_BITS+DIST_W]) begin
      conv_dist = '1;
    end else begin
      conv_dist = acc_q[FRACTION_BITS+DIST_W-1:FRACTION_BITS];
    end
  end

  // Rank the candidate entry against the whole group
  assign cand_val = group_q[cand_q];
  always_comb begin
    lt_cnt = '0;
    le_cnt = '0;
    for (int j = 0; j < GROUP_SIZE; j++) begin
      lt_cnt = lt_cnt + CNT_W'(group_q[j] <  cand_val);
      le_cnt = le_cnt + CNT_W'(group_q[j] <= cand_val);
    end
  end
  assign cand_match = (lt_cnt <= MID_POS) && (le_cnt > MID_POS);

  // Next state and datapath control
  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    x_d         = x_q;
    step_d      = step_q;
    fill_d      = fill_q;
    cand_d      = cand_q;
    med_d       = med_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    store_we    = 1'b0;
    in_ready_o  = (state_q == ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        // Load the cubic coefficient and hold the sample
        if (in_valid_i) begin
          acc_d   = {{(ACC_W - COEF_W){coef_q[0][COEF_W-1]}}, coef_q[0]};
          x_d     = raw_sample_i;
          step_d  = 2'd1;
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        // Advance one Horner step per cycle
        acc_d  = mac_sum;
        step_d = step_q + 2'd1;
        if (step_q == LAST_STEP) begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        // Store the distance; a full group starts the median scan
        store_we = 1'b1;
        if (fill_q == LAST_IDX) begin
          fill_d  = '0;
          cand_d  = '0;
          state_d = ST_MEDIAN;
        end else begin
          fill_d  = fill_q + IDX_W'(1);
          state_d = ST_IDLE;
        end
      end
      ST_MEDIAN: begin
        // Keep the entry whose rank covers the middle position
        if (cand_match) begin
          med_d = cand_val;
        end
        cand_d = cand_q + IDX_W'(1);
        if (cand_q == LAST_IDX) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Clamp into the output register once it is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          if (med_q > high_thr_q) begin
            out_data_d = high_val_q;
          end else if (med_q < low_thr_q) begin
            out_data_d = low_val_q;
          end else begin
            out_data_d = med_q;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      fill_q      <= '0;
      cand_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      fill_q      <= fill_d;
      cand_q      <= cand_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    x_q        <= x_d;
    med_q      <= med_d;
    out_data_q <= out_data_d;
  end

  // Group store write
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      group_q[fill_q] <= conv_dist;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign filtered_distance_o = out_data_q;

endmodule

`default_nettype wire
